// ===== rtl/look_disk_scheduler_core_assert.svh =====
// assertion helpers for the look disk scheduler, clocked on clk, off during reset
`ifndef LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH
`define LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define LDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// shared types and constants of the look disk scheduler
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int MAX_REQ = 64;
    localparam int CYL_W   = 16;
    localparam int KEY_W   = CYL_W + 1;
    localparam int CNT_W   = $clog2(MAX_REQ + 1);
    localparam int SEEK_W  = 17;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_MAX  = 1'b1;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // one slot of the sorting chain; the key orders requests in service order
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } cell_ctrl_t;

    // requests at or above the head sort first ascending, the rest descending
    function automatic logic [KEY_W-1:0] make_key(logic [CYL_W-1:0] cyl,
                                                 logic [CYL_W-1:0] head);
        logic [KEY_W-1:0] k;
        if (cyl >= head)
            k = {1'b0, cyl};
        else
            k = {1'b1, ~cyl};
        return k;
    endfunction

    function automatic logic [CYL_W-1:0] key_cyl(logic [KEY_W-1:0] k);
        logic [CYL_W-1:0] c;
        if (k[KEY_W-1])
            c = ~k[CYL_W-1:0];
        else
            c = k[CYL_W-1:0];
        return c;
    endfunction

endpackage

// ===== rtl/lds_cell.sv =====
// ----------------------------------------------------------------------------
// lds_cell
// one slot of the insertion sorting chain
// ----------------------------------------------------------------------------
module lds_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lds_pkg::cell_ctrl_t         ctrl,
    input  logic [lds_pkg::KEY_W-1:0]   new_key,
    input  logic                        prev_gt,
    input  lds_pkg::entry_t             prev_entry,
    input  lds_pkg::entry_t             next_entry,
    output lds_pkg::entry_t             entry,
    output logic                        gt
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [lds_pkg::KEY_W-1:0] key_reg;
    logic [lds_pkg::KEY_W-1:0] key_next;

    // empty slots behave as larger than anything
    assign gt          = !valid_reg || (key_reg > new_key);
    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next = next_entry.valid;
            key_next   = next_entry.key;
        end
        else if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = new_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/lds_chain.sv =====
// ----------------------------------------------------------------------------
// lds_chain
// row of sorting cells, smallest key at the front
// ----------------------------------------------------------------------------
module lds_chain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lds_pkg::cell_ctrl_t         ctrl,
    input  logic [lds_pkg::KEY_W-1:0]   new_key,
    output lds_pkg::entry_t             front,
    output logic                        second_valid
);

    lds_pkg::entry_t entries [lds_pkg::MAX_REQ];
    logic            gts     [lds_pkg::MAX_REQ];

    genvar i;
    generate
        for (i = 0; i < lds_pkg::MAX_REQ; i++)
        begin : g_cell
            lds_pkg::entry_t prev_e;
            lds_pkg::entry_t next_e;
            logic            prev_g;

            if (i == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = entries[i-1];
                assign prev_g = gts[i-1];
            end

            if (i == lds_pkg::MAX_REQ - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_rest
                assign next_e = entries[i+1];
            end

            lds_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .prev_gt    (prev_g),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (entries[i]),
                .gt         (gts[i])
            );
        end
    endgenerate

    assign front        = entries[0];
    assign second_valid = entries[1].valid;

endmodule

// ===== rtl/look_disk_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// look_disk_scheduler_core
// LOOK disk scheduler: batches cylinder requests and emits the service order
// ----------------------------------------------------------------------------
// Requests load at one per cycle; each of the first 64 of a batch is placed
// at once into a chain of 64 sorting cells keyed by LOOK service order
// relative to the head register. The transaction flagged last_request ends
// the batch and input is then held off while results drain: one result per
// cycle from the front of the chain, paced by out_ready through a single
// output register. The first result is registered once the drain state is
// entered and the output register is free, and input is taken again once the
// final result of the batch sits in the output register. A batch of n good
// requests gives n results; a batch with an error gives one result, and the
// chain is cleared at the same edge that registers it. Configuration writes
// are always taken and must only happen while the block is idle.
module look_disk_scheduler_core (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [15:0]                 cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [15:0]                 request_cylinder,
    input  logic                        last_request,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [15:0]                 served_cylinder,
    output logic [15:0]                 move_distance,
    output logic [16:0]                 total_seek,
    output logic [1:0]                  error_code,
    output logic                        last_result
);

    `include "look_disk_scheduler_core_assert.svh"

    lds_pkg::state_t               state_reg,   state_next;
    logic [lds_pkg::CYL_W-1:0]     head_reg;
    logic [lds_pkg::CYL_W-1:0]     maxc_reg;
    logic [lds_pkg::CNT_W-1:0]     count_reg,   count_next;
    logic [1:0]                    berr_reg,    berr_next;
    logic [1:0]                    err_out_reg, err_out_next;
    logic [lds_pkg::CYL_W-1:0]     pos_reg,     pos_next;
    logic [lds_pkg::SEEK_W-1:0]    total_reg,   total_next;

    logic                          out_valid_reg, out_valid_next;
    logic [lds_pkg::CYL_W-1:0]     served_reg,  served_next;
    logic [lds_pkg::CYL_W-1:0]     move_reg,    move_next;
    logic [lds_pkg::SEEK_W-1:0]    seek_reg,    seek_next;
    logic [1:0]                    ecode_reg,   ecode_next;
    logic                          olast_reg,   olast_next;

    lds_pkg::cell_ctrl_t           ctrl;
    lds_pkg::entry_t               front;
    logic                          second_valid;
    logic [lds_pkg::KEY_W-1:0]     new_key;
    logic                          in_fire;
    logic                          out_free;
    logic [1:0]                    err_upd;
    logic [lds_pkg::CYL_W-1:0]     front_cyl;
    logic [lds_pkg::CYL_W-1:0]     move_dist;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == lds_pkg::ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign new_key   = lds_pkg::make_key(request_cylinder, head_reg);
    assign front_cyl = lds_pkg::key_cyl(front.key);
    assign move_dist = (front_cyl >= pos_reg) ? (front_cyl - pos_reg)
                                              : (pos_reg - front_cyl);

    lds_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_key      (new_key),
        .front        (front),
        .second_valid (second_valid)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        berr_next      = berr_reg;
        err_out_next   = err_out_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        served_next    = served_reg;
        move_next      = move_reg;
        seek_next      = seek_reg;
        ecode_next     = ecode_reg;
        olast_next     = olast_reg;
        ctrl           = '0;
        err_upd        = berr_reg;

        unique case (state_reg)
            lds_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    // first error of the batch wins
                    if (count_reg == lds_pkg::CNT_W'(lds_pkg::MAX_REQ))
                    begin
                        if (berr_reg == lds_pkg::ERR_NONE)
                            err_upd = lds_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        if (request_cylinder > maxc_reg && berr_reg == lds_pkg::ERR_NONE)
                            err_upd = lds_pkg::ERR_RANGE;
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end

                    if (last_request)
                    begin
                        state_next   = lds_pkg::ST_DRAIN;
                        err_out_next = err_upd;
                        count_next   = '0;
                        berr_next    = lds_pkg::ERR_NONE;
                        pos_next     = head_reg;
                        total_next   = '0;
                    end
                    else
                    begin
                        berr_next = err_upd;
                    end
                end
            end

            lds_pkg::ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_out_reg != lds_pkg::ERR_NONE)
                    begin
                        served_next = '0;
                        move_next   = '0;
                        seek_next   = '0;
                        ecode_next  = err_out_reg;
                        olast_next  = 1'b1;
                        ctrl.clear  = 1'b1;
                        state_next  = lds_pkg::ST_LOAD;
                    end
                    else
                    begin
                        served_next = front_cyl;
                        move_next   = move_dist;
                        seek_next   = total_reg + lds_pkg::SEEK_W'(move_dist);
                        ecode_next  = lds_pkg::ERR_NONE;
                        olast_next  = !second_valid;
                        ctrl.pop    = 1'b1;
                        pos_next    = front_cyl;
                        total_next  = total_reg + lds_pkg::SEEK_W'(move_dist);
                        if (!second_valid)
                            state_next = lds_pkg::ST_LOAD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lds_pkg::ST_LOAD;
            head_reg      <= '0;
            maxc_reg      <= '1;
            count_reg     <= '0;
            berr_reg      <= lds_pkg::ERR_NONE;
            err_out_reg   <= lds_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            berr_reg      <= berr_next;
            err_out_reg   <= err_out_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lds_pkg::CFG_HEAD: head_reg <= cfg_data;
                    lds_pkg::CFG_MAX:  maxc_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        total_reg  <= total_next;
        served_reg <= served_next;
        move_reg   <= move_next;
        seek_reg   <= seek_next;
        ecode_reg  <= ecode_next;
        olast_reg  <= olast_next;
    end

    assign out_valid       = out_valid_reg;
    assign served_cylinder = served_reg;
    assign move_distance   = move_reg;
    assign total_seek      = seek_reg;
    assign error_code      = ecode_reg;
    assign last_result     = olast_reg;

    // a pop of a good batch always finds a stored request at the front
    `LDS_ASSERT_SAME(a_pop_has_entry, ctrl.pop, front.valid, "pop from empty sort chain")
    // an error result leaves the chain empty for the next batch
    `LDS_ASSERT_NEXT(a_clear_empties, ctrl.clear, !front.valid, "sort chain not cleared")
    // the fill count never passes the chain length
    `LDS_ASSERT_SAME(a_count_bound, in_fire, count_reg <= lds_pkg::CNT_W'(lds_pkg::MAX_REQ), "request count overflow")

endmodule

// ===== tb/look_disk_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_disk_scheduler_checker
// Watches the request, result and register channels of the LOOK scheduler,
// keeps its own copy of the batch and the registers, works out the service
// order of each batch and compares every accepted result with it.
// ----------------------------------------------------------------------------
module look_disk_scheduler_checker (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [lds_pkg::CYL_W-1:0]  cfg_data,

    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [lds_pkg::CYL_W-1:0]  request_cylinder,
    input  logic                       last_request,

    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [lds_pkg::CYL_W-1:0]  served_cylinder,
    input  logic [lds_pkg::CYL_W-1:0]  move_distance,
    input  logic [lds_pkg::SEEK_W-1:0] total_seek,
    input  logic [1:0]                 error_code,
    input  logic                       last_result,

    output int                         fail_count,
    output int                         pending_results
);

    typedef struct packed {
        logic [lds_pkg::CYL_W-1:0]  served;
        logic [lds_pkg::CYL_W-1:0]  move;
        logic [lds_pkg::SEEK_W-1:0] seek;
        logic [1:0]                 code;
        logic                       last_flag;
    } seek_result_t;

    seek_result_t              service_q[$];
    logic [lds_pkg::CYL_W-1:0] batch_cyls[$];
    logic [1:0]                batch_err;
    logic [lds_pkg::CYL_W-1:0] head_cyl;
    logic [lds_pkg::CYL_W-1:0] max_cyl;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // LOOK order: upward from the head ascending, then the rest descending
    function automatic void schedule_batch();
        logic [lds_pkg::CYL_W-1:0]  ranked[$];
        logic [lds_pkg::CYL_W-1:0]  visit[$];
        logic [lds_pkg::CYL_W-1:0]  cyl;
        logic [lds_pkg::CYL_W-1:0]  pos;
        logic [lds_pkg::CYL_W-1:0]  move;
        logic [lds_pkg::SEEK_W-1:0] seek_sum;
        seek_result_t               res;
        int                         i;
        int                         j;
        int                         split;

        ranked = batch_cyls;
        for (i = 1; i < ranked.size(); i++)
        begin
            cyl = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > cyl)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = cyl;
        end

        split = 0;
        while (split < ranked.size() && ranked[split] < head_cyl)
            split++;
        for (i = split; i < ranked.size(); i++)
            visit.push_back(ranked[i]);
        for (i = split - 1; i >= 0; i--)
            visit.push_back(ranked[i]);

        pos = head_cyl;
        seek_sum = '0;
        for (i = 0; i < visit.size(); i++)
        begin
            move = (visit[i] >= pos) ? visit[i] - pos : pos - visit[i];
            seek_sum = seek_sum + move;
            res.served    = visit[i];
            res.move      = move;
            res.seek      = seek_sum;
            res.code      = lds_pkg::ERR_NONE;
            res.last_flag = (i == visit.size() - 1);
            service_q.push_back(res);
            pos = visit[i];
        end
    endfunction

    always @(posedge clk)
    begin
        seek_result_t want;
        seek_result_t err_res;

        if (!rst_n)
        begin
            service_q.delete();
            batch_cyls.delete();
            batch_err  = lds_pkg::ERR_NONE;
            head_cyl   = '0;
            max_cyl    = '1;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lds_pkg::CFG_HEAD)
                    head_cyl = cfg_data;
                else
                    max_cyl = cfg_data;
            end

            if (out_valid && out_ready)
            begin
                if (service_q.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: cylinder %0d",
                                              served_cylinder));
                else
                begin
                    want = service_q.pop_front();
                    if (served_cylinder !== want.served)
                        report_mismatch($sformatf("served_cylinder %0d, want %0d",
                                                  served_cylinder, want.served));
                    if (move_distance !== want.move)
                        report_mismatch($sformatf("move_distance %0d, want %0d",
                                                  move_distance, want.move));
                    if (total_seek !== want.seek)
                        report_mismatch($sformatf("total_seek %0d, want %0d",
                                                  total_seek, want.seek));
                    if (error_code !== want.code)
                        report_mismatch($sformatf("error_code %0d, want %0d",
                                                  error_code, want.code));
                    if (last_result !== want.last_flag)
                        report_mismatch($sformatf("last_result %0b, want %0b",
                                                  last_result, want.last_flag));
                end
            end

            if (in_valid && in_ready)
            begin
                // a full batch drops the request, otherwise it is range checked
                if (batch_cyls.size() >= lds_pkg::MAX_REQ)
                begin
                    if (batch_err == lds_pkg::ERR_NONE)
                        batch_err = lds_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    if (request_cylinder > max_cyl && batch_err == lds_pkg::ERR_NONE)
                        batch_err = lds_pkg::ERR_RANGE;
                    batch_cyls.push_back(request_cylinder);
                end

                if (last_request)
                begin
                    if (batch_err != lds_pkg::ERR_NONE)
                    begin
                        err_res = '0;
                        err_res.code = batch_err;
                        err_res.last_flag = 1'b1;
                        service_q.push_back(err_res);
                    end
                    else
                        schedule_batch();
                    batch_cyls.delete();
                    batch_err = lds_pkg::ERR_NONE;
                end
            end
        end
        pending_results <= service_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LOOK disk scheduler core
// Directed batches over the register extremes, then random batches under
// three idling patterns with a long output hold-off; the checker compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 8;

    logic                       clk;
    logic                       rst_n            = 1'b0;
    logic                       cfg_valid        = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index        = lds_pkg::CFG_HEAD;
    logic [lds_pkg::CYL_W-1:0]  cfg_data         = '0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic [lds_pkg::CYL_W-1:0]  request_cylinder = '0;
    logic                       last_request     = 1'b0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic [lds_pkg::CYL_W-1:0]  served_cylinder;
    logic [lds_pkg::CYL_W-1:0]  move_distance;
    logic [lds_pkg::SEEK_W-1:0] total_seek;
    logic [1:0]                 error_code;
    logic                       last_result;

    int                         fail_count;
    int                         pending_results;
    int                         send_idle_pct = 17;
    int                         recv_idle_pct = 85;
    logic                       hold_armed    = 1'b0;
    logic [lds_pkg::CYL_W-1:0]  cur_head      = '0;
    logic [lds_pkg::CYL_W-1:0]  cur_max       = '1;
    int                         cycle_count   = 0;

    look_disk_scheduler_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .request_cylinder (request_cylinder),
        .last_request     (last_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .served_cylinder  (served_cylinder),
        .move_distance    (move_distance),
        .total_seek       (total_seek),
        .error_code       (error_code),
        .last_result      (last_result)
    );

    look_disk_scheduler_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .request_cylinder (request_cylinder),
        .last_request     (last_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .served_cylinder  (served_cylinder),
        .move_distance    (move_distance),
        .total_seek       (total_seek),
        .error_code       (error_code),
        .last_result      (last_result),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off once armed
    initial
    begin : receiver
        bit hold_done;

        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done && out_valid)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [lds_pkg::CYL_W-1:0] cyl, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid         <= 1'b1;
        request_cylinder <= cyl;
        last_request     <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid, wait for every pending result, then let the chain settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic configure(input logic [lds_pkg::CYL_W-1:0] head,
                             input logic [lds_pkg::CYL_W-1:0] maxc);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= lds_pkg::CFG_HEAD;
        cfg_data  <= head;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= lds_pkg::CFG_MAX;
        cfg_data  <= maxc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_head = head;
        cur_max  = maxc;
    endtask

    function automatic logic [lds_pkg::CYL_W-1:0] pick_cylinder();
        int unsigned sel;
        int          near;

        sel = $urandom_range(19);
        if (sel == 0)
            return cur_max;
        if (sel == 1)
            return '0;
        if (sel <= 6)
        begin
            near = int'(cur_head) + int'($urandom_range(16)) - 8;
            if (near < 0)
                near = 0;
            if (near > int'(cur_max))
                near = int'(cur_max);
            return near[lds_pkg::CYL_W-1:0];
        end
        return lds_pkg::CYL_W'($urandom_range(cur_max, 0));
    endfunction

    function automatic logic [lds_pkg::CYL_W-1:0] pick_out_of_range();
        return lds_pkg::CYL_W'($urandom_range(65535, cur_max + 1));
    endfunction

    task automatic send_batch(input int n, input int bad_at);
        int i;

        for (i = 0; i < n; i++)
            send_request((i == bad_at) ? pick_out_of_range() : pick_cylinder(), i == n - 1);
    endtask

    task automatic random_phase(input int goal);
        int sent;
        int n;
        int bad_at;
        int batches;

        sent = 0;
        batches = 0;
        while (sent < goal)
        begin
            if (batches % 5 == 0)
                configure(lds_pkg::CYL_W'($urandom_range(65535)),
                          $urandom_range(1) ? 16'hFFFF
                                            : lds_pkg::CYL_W'($urandom_range(65535)));
            if ($urandom_range(29) == 0)
                n = lds_pkg::MAX_REQ + $urandom_range(3, 1);
            else if ($urandom_range(9) == 0)
                n = $urandom_range(24, 9);
            else
                n = $urandom_range(8, 1);
            bad_at = -1;
            if (cur_max != 16'hFFFF && $urandom_range(7) == 0)
                bad_at = $urandom_range(n - 1, 0);
            send_batch(n, bad_at);
            sent += n;
            batches++;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: head 0, max 65535; request at the head moves 0
        send_request(16'd0, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd0, 1'b1);

        // requests at, below and above the head, full range
        configure(16'd1000, 16'hFFFF);
        send_request(16'd1000, 1'b0);
        send_request(16'd5, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd999, 1'b0);
        send_request(16'd1001, 1'b1);

        // request above the max cylinder rejects the batch
        configure(16'd1000, 16'd2000);
        send_request(16'd2001, 1'b0);
        send_request(16'd3, 1'b1);

        // head above max: a single downward sweep
        configure(16'hFFFF, 16'd100);
        send_request(16'd100, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd50, 1'b1);

        configure(16'd0, 16'd0);
        send_request(16'd0, 1'b0);
        send_request(16'd0, 1'b1);

        configure(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd1, 1'b1);

        send_idle_pct = 17;
        recv_idle_pct = 85;
        random_phase(12);

        send_idle_pct = 85;
        recv_idle_pct = 17;
        random_phase(12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // full batch while the result side holds off; an overflow batch keeps
        // offering, and its dropped request lies above the max cylinder
        configure(16'd30000, 16'd60000);
        hold_armed = 1'b1;
        send_batch(lds_pkg::MAX_REQ, -1);
        send_batch(lds_pkg::MAX_REQ + 1, lds_pkg::MAX_REQ);
        random_phase(8);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
